/* sv/pmr_pkg.sv */
// Shared constants and handshake structs for the ranged minimal-standard generator.
package pmr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned NUM_W  = 64;
  localparam int unsigned CNT_W  = 6;

  localparam logic [31:0] SCHRAGE_Q   = 32'd127773;
  localparam logic [14:0] SCHRAGE_A   = 15'd16807;
  localparam logic [11:0] SCHRAGE_R   = 12'd2836;
  localparam logic [30:0] RANDMAX     = 31'h7FFF_FFFF;
  localparam logic [31:0] SEED_RESET  = 32'd1;

  localparam logic [CNT_W-1:0] BITS_STATE = 6'd32;
  localparam logic [CNT_W-1:0] BITS_RAW   = 6'd31;
  localparam logic [CNT_W-1:0] BITS_WIDE  = 6'd63;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [31:0]       den;
    logic [CNT_W-1:0]  nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [NUM_W-1:0]  quot;
    logic [31:0]       rem;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [30:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [62:0] prod;
  } mul_rsp_t;

endpackage

/* sv/pmr_channels.sv */
// Valid/ready channel interfaces for request, result and seed transactions.
interface pmr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] bound_a;
  logic [31:0] bound_b;

  modport source (output valid, output mode, output bound_a, output bound_b, input ready);
  modport sink   (input valid, input mode, input bound_a, input bound_b, output ready);
endinterface

interface pmr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface pmr_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

/* sv/pmr_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module pmr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pmr_pkg::div_req_t  req,
  output pmr_pkg::div_rsp_t  rsp
);

  logic [pmr_pkg::NUM_W-1:0] num_r;
  logic [31:0]               rem_r;
  logic [31:0]               den_r;
  logic [pmr_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r;
  logic                      done_r;

  logic [32:0] rem_sh;
  logic [33:0] diff;
  logic        ge;

  assign rem_sh = {rem_r, num_r[pmr_pkg::NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge     = ~diff[33];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[pmr_pkg::NUM_W-2:0], ge};
      rem_r <= ge ? diff[31:0] : rem_sh[31:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;
  assign rsp.rem  = rem_r;

endmodule

/* sv/pmr_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module pmr_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  pmr_pkg::mul_req_t  req,
  output pmr_pkg::mul_rsp_t  rsp
);

  logic [62:0] acc_r;
  logic [62:0] mcand_r;
  logic [31:0] mplier_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r    <= '0;
      mcand_r  <= {32'b0, req.a};
      mplier_r <= req.b;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[61:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[31:1]};
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

/* sv/park_miller_ranged_random_core.sv */
// Ranged minimal-standard generator core: sequencer around a serial divider and multiplier.
// Raw mode runs a 32-bit Schrage divide by 127773, then the state step.
// Ranged mode with a span below 2^31 adds two 31-bit divides.
// Ranged mode with a wider span adds a 32-bit multiply and a 63-bit divide.
// One request at a time: a new one is taken only in idle; results wait in the output register.
// Synchronous active-low reset loads generator state 1 and empties the output register.
module park_miller_ranged_random_core (
  input  logic      clk,
  input  logic      rst_n,
  pmr_in_if.sink    in_chan,
  pmr_out_if.source out_chan,
  pmr_cfg_if.sink   cfg_chan
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_DIVS = 10'b00_0000_0010,
    S_STEP = 10'b00_0000_0100,
    S_MAP  = 10'b00_0000_1000,
    S_SEL  = 10'b00_0001_0000,
    S_DIVR = 10'b00_0010_0000,
    S_DIVV = 10'b00_0100_0000,
    S_MULW = 10'b00_1000_0000,
    S_DIVW = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] gen_r;
  logic        mode_r;
  logic [31:0] bound_a_r;
  logic [31:0] bound_b_r;
  logic        neg_r;
  logic [30:0] p1_r;
  logic [25:0] p2_r;
  logic [30:0] raw_r;
  logic [31:0] lo_r;
  logic [31:0] span_r;
  logic [31:0] res_r;
  logic [31:0] out_value_r;
  logic        out_valid_r;

  pmr_pkg::div_req_t div_req;
  pmr_pkg::div_rsp_t div_rsp;
  pmr_pkg::mul_req_t mul_req;
  pmr_pkg::mul_rsp_t mul_rsp;

  logic        in_fire;
  logic        cfg_fire;
  logic        out_load;
  logic [31:0] mag;
  logic [33:0] t_pos;
  logic [33:0] t_val;
  logic [33:0] t_add;
  logic [33:0] t_fix;
  logic        b_lt_a;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_fire        = in_chan.valid & in_chan.ready;
  assign cfg_fire       = cfg_chan.valid & cfg_chan.ready;
  assign out_load       = (state_r == S_OUT) & (~out_valid_r | out_chan.ready);

  assign mag    = gen_r[31] ? (~gen_r + 32'd1) : gen_r;
  assign t_pos  = {3'b000, p1_r} - {8'b0, p2_r};
  assign t_val  = neg_r ? (34'd0 - t_pos) : t_pos;
  assign t_add  = (t_val == 34'd0) ? {3'b000, pmr_pkg::RANDMAX - 31'd1} :
                  t_val[33]        ? {3'b000, pmr_pkg::RANDMAX} : 34'd0;
  assign t_fix  = t_val + t_add;
  assign b_lt_a = $signed(bound_b_r) < $signed(bound_a_r);

  pmr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pmr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    div_req       = '0;
    mul_req       = '0;
    mul_req.a     = raw_r;
    mul_req.b     = span_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          div_req.start = 1'b1;
          div_req.num   = {mag, 32'b0};
          div_req.den   = pmr_pkg::SCHRAGE_Q;
          div_req.nbits = pmr_pkg::BITS_STATE;
          state_nxt     = S_DIVS;
        end
      end
      S_DIVS: begin
        if (div_rsp.done) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        state_nxt = S_MAP;
      end
      S_MAP: begin
        state_nxt = mode_r ? S_SEL : S_OUT;
      end
      S_SEL: begin
        if (span_r[31]) begin
          mul_req.start = 1'b1;
          state_nxt     = S_MULW;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = {pmr_pkg::RANDMAX, 33'b0};
          div_req.den   = span_r + 32'd1;
          div_req.nbits = pmr_pkg::BITS_RAW;
          state_nxt     = S_DIVR;
        end
      end
      S_DIVR: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = {raw_r, 33'b0};
          div_req.den   = {1'b0, div_rsp.quot[30:0]} + 32'd1;
          div_req.nbits = pmr_pkg::BITS_RAW;
          state_nxt     = S_DIVV;
        end
      end
      S_DIVV: begin
        if (div_rsp.done) begin
          state_nxt = S_OUT;
        end
      end
      S_MULW: begin
        if (mul_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = {mul_rsp.prod, 1'b0};
          div_req.den   = {1'b0, pmr_pkg::RANDMAX};
          div_req.nbits = pmr_pkg::BITS_WIDE;
          state_nxt     = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gen_r       <= pmr_pkg::SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        gen_r <= cfg_chan.seed;
      end else if (state_r == S_STEP) begin
        gen_r <= t_fix[31:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r    <= in_chan.mode;
      bound_a_r <= in_chan.bound_a;
      bound_b_r <= in_chan.bound_b;
      neg_r     <= gen_r[31];
    end
    if ((state_r == S_DIVS) && div_rsp.done) begin
      p1_r <= {14'b0, div_rsp.rem[16:0]} * {16'b0, pmr_pkg::SCHRAGE_A};
      p2_r <= {11'b0, div_rsp.quot[14:0]} * {14'b0, pmr_pkg::SCHRAGE_R};
    end
    if (state_r == S_STEP) begin
      raw_r <= t_fix[30:0];
    end
    if (state_r == S_MAP) begin
      lo_r   <= b_lt_a ? bound_b_r : bound_a_r;
      span_r <= b_lt_a ? (bound_a_r - bound_b_r) : (bound_b_r - bound_a_r);
      res_r  <= {1'b0, raw_r};
    end
    if (((state_r == S_DIVV) || (state_r == S_DIVW)) && div_rsp.done) begin
      res_r <= lo_r + div_rsp.quot[31:0];
    end
    if (out_load) begin
      out_value_r <= res_r;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.value = out_value_r;

endmodule
